// ----- rtl/wpa_rsn_ie_parser_macros.svh -----
// Assertion macros used by the checker file of the parser.
`ifndef WPA_RSN_IE_PARSER_MACROS_SVH
`define WPA_RSN_IE_PARSER_MACROS_SVH

// Same-cycle implication under reset.
`define WRP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication under reset.
`define WRP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/wrp_pkg.sv -----
package wrp_pkg;

	localparam int MAX_BUFFER_BYTES_DEF = 4096;
	localparam int NUM_OUT = 5;
	localparam int FIFO_DEPTH = 8;

	localparam logic [7:0] IE_RSN = 8'h30;
	localparam logic [7:0] IE_VENDOR = 8'hdd;
	localparam logic [7:0] WPA_OUI_0 = 8'h00;
	localparam logic [7:0] WPA_OUI_1 = 8'h50;
	localparam logic [7:0] WPA_OUI_2 = 8'hf2;
	localparam logic [7:0] WPA_OUI_TYPE = 8'h01;
	localparam logic [7:0] RSN_OUI_0 = 8'h00;
	localparam logic [7:0] RSN_OUI_1 = 8'h0f;
	localparam logic [7:0] RSN_OUI_2 = 8'hac;

	typedef logic [1:0] ekind_t;
	localparam ekind_t EK_SKIP = 2'd0;
	localparam ekind_t EK_WPA = 2'd1;
	localparam ekind_t EK_RSN = 2'd2;

	typedef enum logic [2:0] {
		RK_TYPE = 3'd0,
		RK_VERSION = 3'd1,
		RK_GROUP = 3'd2,
		RK_PCOUNT = 3'd3,
		RK_PCIPHER = 3'd4,
		RK_ACOUNT = 3'd5,
		RK_ASUITE = 3'd6,
		RK_PREAUTH = 3'd7
	} rkind_t;

	localparam logic [15:0] TV_UNKNOWN = 16'd0;
	localparam logic [15:0] TV_WPA = 16'd1;
	localparam logic [15:0] TV_RSN = 16'd2;
	localparam logic [15:0] CIPHER_TKIP = 16'd2;
	localparam logic [15:0] CIPHER_UNKNOWN = 16'd6;
	localparam logic [15:0] CIPHER_PROP = 16'd7;
	localparam logic [15:0] AUTH_UNKNOWN = 16'd3;

	typedef struct packed {
		logic [10:0] element_number;
		rkind_t report_kind;
		logic [15:0] report_value;
		logic [5:0] entry_index;
		logic last_of_run;
	} result_t;

	typedef struct packed {
		logic [2:0] count;
		result_t [NUM_OUT-1:0] item;
	} run_t;

	function automatic logic [7:0] oui_byte(input ekind_t k, input logic [1:0] i);
		logic [7:0] r;
		r = 8'h00;
		if (k == EK_WPA) begin
			case (i)
				2'd0: r = WPA_OUI_0;
				2'd1: r = WPA_OUI_1;
				2'd2: r = WPA_OUI_2;
				default: r = WPA_OUI_TYPE;
			endcase
		end else if (k == EK_RSN) begin
			case (i)
				2'd0: r = RSN_OUI_0;
				2'd1: r = RSN_OUI_1;
				2'd2: r = RSN_OUI_2;
				default: r = 8'h00;
			endcase
		end
		return r;
	endfunction

	function automatic logic [15:0] cipher_code(input logic match, input logic [7:0] b);
		logic [15:0] r;
		if (!match)
			r = CIPHER_PROP;
		else if (b < 8'd6)
			r = {8'h00, b};
		else
			r = CIPHER_UNKNOWN;
		return r;
	endfunction

	function automatic logic [15:0] auth_code(input logic match, input logic [7:0] b);
		logic [15:0] r;
		if (!match)
			r = AUTH_UNKNOWN;
		else if (b < 8'd3)
			r = {8'h00, b};
		else
			r = AUTH_UNKNOWN;
		return r;
	endfunction

	function automatic result_t make_result(input logic [10:0] num, input rkind_t k,
			input logic [15:0] v, input logic [5:0] idx);
		result_t r;
		r.element_number = num;
		r.report_kind = k;
		r.report_value = v;
		r.entry_index = idx;
		r.last_of_run = 1'b0;
		return r;
	endfunction

endpackage

// ----- rtl/wrp_core.sv -----
module wrp_core #(
	parameter int MAX_BUFFER_BYTES = wrp_pkg::MAX_BUFFER_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  logic [7:0] data_byte,
	input  logic buffer_start,
	input  logic [12:0] buffer_length,
	output wrp_pkg::run_t run
);
	import wrp_pkg::*;

	localparam int BL_W = $clog2(MAX_BUFFER_BYTES + 1);
	localparam int BP_W = BL_W + 1;
	localparam int CW = (BL_W > 13) ? BL_W : 13;
	localparam int LW = 19;

	typedef enum logic [10:0] {
		PH_HDR = 11'b000_0000_0001,
		PH_LEN = 11'b000_0000_0010,
		PH_SKIP = 11'b000_0000_0100,
		PH_OUI = 11'b000_0000_1000,
		PH_VER = 11'b000_0001_0000,
		PH_GROUP = 11'b000_0010_0000,
		PH_PCNT = 11'b000_0100_0000,
		PH_PLIST = 11'b000_1000_0000,
		PH_ACNT = 11'b001_0000_0000,
		PH_ALIST = 11'b010_0000_0000,
		PH_CAP = 11'b100_0000_0000
	} phase_t;

	logic [BL_W-1:0] bytes_left_q, bl, nbl, bl_sat;
	logic [8:0] pos_q, pos, npos, nxt_pos;
	logic [8:0] elen_q, nelen, ielen;
	ekind_t kind_q, kind, nkind;
	phase_t phase_q, ph, nph;
	logic om_q, nom;
	logic [15:0] acc_q, nacc, word;
	logic [15:0] lc_q, nlc;
	logic [5:0] li_q, nli, li_inc;
	logic [10:0] cnt_q, cnt, ncnt;
	logic [1:0] fb_q, fb, nfb;
	logic [CW-1:0] blen_x, max_x;
	logic [BP_W-1:0] bl_p1;
	logic [LW-1:0] list_end;
	logic [2:0] n;
	result_t [NUM_OUT-1:0] items;

	assign blen_x = CW'(buffer_length);
	assign max_x = CW'(MAX_BUFFER_BYTES);
	assign bl_sat = (blen_x > max_x) ? max_x[BL_W-1:0] : blen_x[BL_W-1:0];

	always_comb begin
		bl = buffer_start ? bl_sat : bytes_left_q;
		ph = buffer_start ? PH_HDR : phase_q;
		pos = buffer_start ? 9'd0 : pos_q;
		kind = buffer_start ? EK_SKIP : kind_q;
		cnt = buffer_start ? 11'd0 : cnt_q;
		fb = buffer_start ? 2'd0 : fb_q;

		nbl = bl;
		nph = ph;
		npos = pos;
		nkind = kind;
		ncnt = cnt;
		nfb = fb;
		nom = om_q;
		nacc = acc_q;
		nlc = lc_q;
		nli = li_q;
		nelen = elen_q;
		n = 3'd0;
		items = '0;

		nxt_pos = pos + 9'd1;
		word = {data_byte, acc_q[7:0]};
		li_inc = li_q + 6'd1;
		bl_p1 = BP_W'(bl) + BP_W'(1);
		ielen = {1'b0, data_byte} + 9'd2;
		if (BP_W'(ielen) > bl_p1)
			ielen = bl_p1[8:0];
		list_end = LW'(nxt_pos) + {1'b0, word, 2'b00};

		if (bl != '0) begin
			if (ph == PH_HDR) begin
				if (bl >= BL_W'(2)) begin
					if (data_byte == IE_RSN)
						nkind = EK_RSN;
					else if (data_byte == IE_VENDOR)
						nkind = EK_WPA;
					else
						nkind = EK_SKIP;
					if (nkind != EK_SKIP)
						ncnt = cnt + 11'd1;
					nph = PH_LEN;
					npos = 9'd1;
				end
				nbl = bl - BL_W'(1);
			end else begin
				case (ph)
					PH_LEN: begin
						nelen = ielen;
						nph = PH_SKIP;
						nfb = 2'd0;
						if (kind == EK_RSN) begin
							if (ielen < 9'd4) begin
								items[n] = make_result(cnt - 11'd1, RK_TYPE, TV_UNKNOWN, 6'd0);
								n = n + 3'd1;
							end else begin
								nph = PH_VER;
							end
						end else if (kind == EK_WPA) begin
							if (ielen < 9'd8) begin
								items[n] = make_result(cnt - 11'd1, RK_TYPE, TV_UNKNOWN, 6'd0);
								n = n + 3'd1;
							end else begin
								nph = PH_OUI;
								nom = 1'b1;
							end
						end
					end
					PH_OUI: begin
						nom = om_q && (data_byte == oui_byte(EK_WPA, pos[1:0] - 2'd2));
						if (pos >= 9'd5) begin
							if (!nom) begin
								items[n] = make_result(cnt - 11'd1, RK_TYPE, TV_UNKNOWN, 6'd0);
								n = n + 3'd1;
								nph = PH_SKIP;
							end else begin
								nph = PH_VER;
								nfb = 2'd0;
							end
						end
					end
					PH_VER: begin
						if (fb == 2'd0) begin
							nacc = {8'h00, data_byte};
							nfb = 2'd1;
						end else begin
							nacc = word;
							nfb = 2'd0;
							items[n] = make_result(cnt - 11'd1, RK_TYPE,
								(kind == EK_WPA) ? TV_WPA : TV_RSN, 6'd0);
							n = n + 3'd1;
							items[n] = make_result(cnt - 11'd1, RK_VERSION, word, 6'd0);
							n = n + 3'd1;
							if ({1'b0, elen_q} < {1'b0, nxt_pos} + 10'd4) begin
								items[n] = make_result(cnt - 11'd1, RK_GROUP, CIPHER_TKIP, 6'd0);
								n = n + 3'd1;
								items[n] = make_result(cnt - 11'd1, RK_PCIPHER, CIPHER_TKIP, 6'd0);
								n = n + 3'd1;
								items[n] = make_result(cnt - 11'd1, RK_PCOUNT, 16'd1, 6'd0);
								n = n + 3'd1;
								nph = PH_SKIP;
							end else begin
								nph = PH_GROUP;
								nom = 1'b1;
							end
						end
					end
					PH_GROUP: begin
						if (fb != 2'd3) begin
							if (data_byte != oui_byte(kind, fb))
								nom = 1'b0;
							nfb = fb + 2'd1;
						end else begin
							nfb = 2'd0;
							items[n] = make_result(cnt - 11'd1, RK_GROUP,
								cipher_code(om_q, data_byte), 6'd0);
							n = n + 3'd1;
							if ({1'b0, elen_q} < {1'b0, nxt_pos} + 10'd2) begin
								items[n] = make_result(cnt - 11'd1, RK_PCIPHER, CIPHER_TKIP, 6'd0);
								n = n + 3'd1;
								items[n] = make_result(cnt - 11'd1, RK_PCOUNT, 16'd1, 6'd0);
								n = n + 3'd1;
								nph = PH_SKIP;
							end else begin
								nph = PH_PCNT;
							end
						end
					end
					PH_PCNT: begin
						if (fb == 2'd0) begin
							nacc = {8'h00, data_byte};
							nfb = 2'd1;
						end else begin
							nacc = word;
							nfb = 2'd0;
							nlc = word;
							nli = 6'd0;
							items[n] = make_result(cnt - 11'd1, RK_PCOUNT, word, 6'd0);
							n = n + 3'd1;
							if (LW'(elen_q) < list_end) begin
								nph = PH_SKIP;
							end else if (word != 16'd0) begin
								nph = PH_PLIST;
								nom = 1'b1;
							end else if ({1'b0, elen_q} < {1'b0, nxt_pos} + 10'd2) begin
								nph = PH_SKIP;
							end else begin
								nph = PH_ACNT;
							end
						end
					end
					PH_PLIST: begin
						if (fb != 2'd3) begin
							if (data_byte != oui_byte(kind, fb))
								nom = 1'b0;
							nfb = fb + 2'd1;
						end else begin
							items[n] = make_result(cnt - 11'd1, RK_PCIPHER,
								cipher_code(om_q, data_byte), li_q);
							n = n + 3'd1;
							nli = li_inc;
							nfb = 2'd0;
							nom = 1'b1;
							if (16'(li_inc) >= lc_q) begin
								if ({1'b0, elen_q} < {1'b0, nxt_pos} + 10'd2)
									nph = PH_SKIP;
								else
									nph = PH_ACNT;
							end
						end
					end
					PH_ACNT: begin
						if (fb == 2'd0) begin
							nacc = {8'h00, data_byte};
							nfb = 2'd1;
						end else begin
							nacc = word;
							nfb = 2'd0;
							nlc = word;
							nli = 6'd0;
							items[n] = make_result(cnt - 11'd1, RK_ACOUNT, word, 6'd0);
							n = n + 3'd1;
							if (LW'(elen_q) < list_end) begin
								nph = PH_SKIP;
							end else if (word != 16'd0) begin
								nph = PH_ALIST;
								nom = 1'b1;
							end else if (elen_q <= nxt_pos) begin
								nph = PH_SKIP;
							end else begin
								nph = PH_CAP;
							end
						end
					end
					PH_ALIST: begin
						if (fb != 2'd3) begin
							if (data_byte != oui_byte(kind, fb))
								nom = 1'b0;
							nfb = fb + 2'd1;
						end else begin
							items[n] = make_result(cnt - 11'd1, RK_ASUITE,
								auth_code(om_q, data_byte), li_q);
							n = n + 3'd1;
							nli = li_inc;
							nfb = 2'd0;
							nom = 1'b1;
							if (16'(li_inc) >= lc_q) begin
								if (elen_q <= nxt_pos)
									nph = PH_SKIP;
								else
									nph = PH_CAP;
							end
						end
					end
					PH_CAP: begin
						items[n] = make_result(cnt - 11'd1, RK_PREAUTH,
							{15'd0, data_byte[0]}, 6'd0);
						n = n + 3'd1;
						nph = PH_SKIP;
					end
					default: begin
						nph = PH_SKIP;
					end
				endcase
				nbl = bl - BL_W'(1);
				if (nxt_pos >= nelen) begin
					nph = PH_HDR;
					npos = 9'd0;
				end else begin
					npos = nxt_pos;
				end
			end
		end

		if (n != 3'd0)
			items[n - 3'd1].last_of_run = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= '0;
			pos_q <= 9'd0;
			elen_q <= 9'd0;
			kind_q <= EK_SKIP;
			phase_q <= PH_HDR;
			om_q <= 1'b1;
			acc_q <= 16'd0;
			lc_q <= 16'd0;
			li_q <= 6'd0;
			cnt_q <= 11'd0;
			fb_q <= 2'd0;
		end else if (in_fire) begin
			bytes_left_q <= nbl;
			pos_q <= npos;
			elen_q <= nelen;
			kind_q <= nkind;
			phase_q <= nph;
			om_q <= nom;
			acc_q <= nacc;
			lc_q <= nlc;
			li_q <= nli;
			cnt_q <= ncnt;
			fb_q <= nfb;
		end
	end

	assign run.count = n;
	assign run.item = items;

endmodule

// ----- rtl/wrp_fifo.sv -----
module wrp_fifo (
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  wrp_pkg::run_t run,
	output logic space_ok,
	output logic m_valid,
	input  logic m_ready,
	output wrp_pkg::result_t m_item
);
	import wrp_pkg::*;

	localparam int PW = $clog2(FIFO_DEPTH);
	localparam int CNT_W = PW + 1;

	result_t mem_q [FIFO_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic [2:0] push_n;
	logic pop;

	assign push_n = in_fire ? run.count : 3'd0;
	assign m_valid = (cnt_q != '0);
	assign pop = m_valid && m_ready;
	assign space_ok = (cnt_q <= CNT_W'(FIFO_DEPTH - NUM_OUT));
	assign m_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(push_n);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PW'(1);
			cnt_q <= cnt_q + CNT_W'(push_n) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_OUT; i++) begin
			if (3'(i) < push_n)
				mem_q[wr_ptr_q + PW'(i)] <= run.item[i];
		end
	end

endmodule

// ----- rtl/wpa_rsn_ie_parser.sv -----
// WPA/RSN information element parser. Bytes of an 802.11 element buffer enter
// on the slave stream, one beat per byte, with the buffer length on the beat
// that marks the buffer start; each WPA or RSN element yields a run of reports
// on the master stream, the final report of a byte's run flagged by tlast. A
// byte is parsed in the cycle it is accepted and its reports, up to five, go
// into an eight-entry report queue; a byte is accepted in any cycle in which
// the queue holds three or fewer reports. Reports leave at one per cycle while
// m_tready is high; the rate is set by the width of the single output port of
// the queue. Reset is ready at once, with no clearing pass.
module wpa_rsn_ie_parser #(
	parameter int MAX_BUFFER_BYTES = wrp_pkg::MAX_BUFFER_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [23:0] s_tdata,  // data_byte[7:0], buffer_length[20:8], zero fill
	input  logic s_tuser,         // buffer_start
	output logic m_tvalid,
	input  logic m_tready,
	output logic [39:0] m_tdata,  // element_number[10:0], report_value[26:11],
	                              // entry_index[32:27], zero fill
	output logic [2:0] m_tuser,   // report_kind
	output logic m_tlast          // last_of_run
);
	import wrp_pkg::*;

	logic in_fire;
	logic space_ok;
	run_t run;
	result_t item;

	assign s_tready = space_ok;
	assign in_fire = s_tvalid && s_tready;

	wrp_core #(
		.MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.in_fire(in_fire),
		.data_byte(s_tdata[7:0]),
		.buffer_start(s_tuser),
		.buffer_length(s_tdata[20:8]),
		.run(run)
	);

	wrp_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.in_fire(in_fire),
		.run(run),
		.space_ok(space_ok),
		.m_valid(m_tvalid),
		.m_ready(m_tready),
		.m_item(item)
	);

	assign m_tdata = {7'd0, item.entry_index, item.report_value, item.element_number};
	assign m_tuser = item.report_kind;
	assign m_tlast = item.last_of_run;

endmodule

// ----- rtl/wrp_checker.sv -----
`include "wpa_rsn_ie_parser_macros.svh"

module wrp_checker (
	input logic clk,
	input logic arst_n,
	input logic m_tvalid,
	input logic m_tready,
	input logic [39:0] m_tdata,
	input logic [2:0] m_tuser,
	input logic m_tlast
);
	import wrp_pkg::*;

	`WRP_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
		"Stalled output beat changed.")

	`WRP_ASSERT_IMP(a_index_kind, clk, arst_n, m_tvalid && (m_tdata[32:27] != 6'd0),
		(m_tuser == RK_PCIPHER) || (m_tuser == RK_ASUITE),
		"Entry index set on a report that is not a list entry.")

	`WRP_ASSERT_IMP(a_type_range, clk, arst_n, m_tvalid && (m_tuser == RK_TYPE),
		m_tdata[26:11] <= TV_RSN, "Element type report out of range.")

	`WRP_ASSERT_IMP(a_auth_range, clk, arst_n, m_tvalid && (m_tuser == RK_ASUITE),
		m_tdata[26:11] <= AUTH_UNKNOWN, "Auth suite report out of range.")

endmodule

bind wpa_rsn_ie_parser wrp_checker u_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tuser(m_tuser),
	.m_tlast(m_tlast)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
	import wrp_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam logic [31:0] WPA_OUI_WORD = {WPA_OUI_TYPE, WPA_OUI_2, WPA_OUI_1, WPA_OUI_0};
	localparam logic [31:0] RSN_OUI_WORD = {8'h00, RSN_OUI_2, RSN_OUI_1, RSN_OUI_0};
	localparam logic [7:0] IE_OTHER = 8'hff;

	typedef enum logic [3:0] {
		P_HDR, P_LEN, P_SKIP, P_OUI, P_VER, P_GROUP,
		P_PCNT, P_PLIST, P_ACNT, P_ALIST, P_CAP
	} walk_phase_t;

	typedef struct {
		logic [7:0] b;
		logic st;
		logic [12:0] blen;
		int gap;
	} ie_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [23:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [2:0] m_tuser;
	logic m_tlast;

	ie_beat_t ie_stream[$];
	ie_beat_t next_beat;
	logic [7:0] ie_bytes[$];
	logic [7:0] elem_body[$];
	result_t predicted_reports[$];
	result_t want;
	bit src_calm = 1'b0;
	bit sink_calm = 1'b0;
	int idle_left = 0;
	int stall_left = 0;
	int stall_draw;
	int err_count = 0;
	int cycle_count = 0;

	logic [12:0] bytes_left = '0;
	logic [8:0] elem_pos = '0;
	logic [8:0] elem_len = '0;
	ekind_t elem_kind = EK_SKIP;
	walk_phase_t phase = P_HDR;
	logic oui_ok = 1'b1;
	logic [15:0] word_acc = '0;
	logic [15:0] list_cnt = '0;
	logic [5:0] list_idx = '0;
	logic [10:0] elem_count = '0;
	logic [1:0] fbyte = '0;

	wpa_rsn_ie_parser i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	function automatic void add_report(input rkind_t k, input logic [15:0] v,
			input logic [5:0] idx);
		result_t r;
		r.element_number = elem_count - 11'd1;
		r.report_kind = k;
		r.report_value = v;
		r.entry_index = idx;
		r.last_of_run = 1'b0;
		predicted_reports.push_back(r);
	endfunction

	function automatic bit take_word(input logic [7:0] b);
		if (fbyte == 2'd0) begin
			word_acc = {8'h00, b};
			fbyte = 2'd1;
			return 1'b0;
		end
		word_acc[15:8] = b;
		fbyte = 2'd0;
		return 1'b1;
	endfunction

	function automatic bit take_suite(input logic [7:0] b);
		logic [31:0] w;
		w = (elem_kind == EK_WPA) ? WPA_OUI_WORD : RSN_OUI_WORD;
		if (fbyte < 2'd3) begin
			if (b != w[8*fbyte +: 8])
				oui_ok = 1'b0;
			fbyte = fbyte + 2'd1;
			return 1'b0;
		end
		fbyte = 2'd0;
		return 1'b1;
	endfunction

	function automatic void open_suite();
		fbyte = 2'd0;
		oui_ok = 1'b1;
	endfunction

	function automatic logic [15:0] cipher_of(input logic [7:0] sel);
		if (!oui_ok)
			return CIPHER_PROP;
		return (sel < 8'd6) ? {8'h00, sel} : CIPHER_UNKNOWN;
	endfunction

	function automatic logic [15:0] auth_of(input logic [7:0] sel);
		if (!oui_ok || sel >= 8'd3)
			return AUTH_UNKNOWN;
		return {8'h00, sel};
	endfunction

	task automatic walk_ie_byte(input logic [7:0] b, input logic st, input logic [12:0] blen);
		int nxt;
		int ln;
		int n_before;
		n_before = predicted_reports.size();
		if (st) begin
			bytes_left = (blen > MAX_BUFFER_BYTES_DEF) ? 13'(MAX_BUFFER_BYTES_DEF) : blen;
			phase = P_HDR;
			elem_pos = '0;
			elem_kind = EK_SKIP;
			elem_count = '0;
			fbyte = '0;
		end
		if (bytes_left == 13'd0)
			return;
		if (phase == P_HDR) begin
			if (bytes_left >= 13'd2) begin
				if (b == IE_RSN)
					elem_kind = EK_RSN;
				else if (b == IE_VENDOR)
					elem_kind = EK_WPA;
				else
					elem_kind = EK_SKIP;
				if (elem_kind != EK_SKIP)
					elem_count = elem_count + 11'd1;
				phase = P_LEN;
				elem_pos = 9'd1;
			end
			bytes_left = bytes_left - 13'd1;
			return;
		end
		nxt = elem_pos + 1;
		case (phase)
			P_LEN: begin
				ln = b + 2;
				if (ln > bytes_left + 1)
					ln = bytes_left + 1;
				elem_len = ln[8:0];
				phase = P_SKIP;
				fbyte = '0;
				if (elem_kind == EK_RSN) begin
					if (ln < 4)
						add_report(RK_TYPE, TV_UNKNOWN, 6'd0);
					else
						phase = P_VER;
				end else if (elem_kind == EK_WPA) begin
					if (ln < 8) begin
						add_report(RK_TYPE, TV_UNKNOWN, 6'd0);
					end else begin
						phase = P_OUI;
						oui_ok = 1'b1;
					end
				end
			end
			P_OUI: begin
				if (b != WPA_OUI_WORD[8*((elem_pos - 2) & 3) +: 8])
					oui_ok = 1'b0;
				if (elem_pos >= 9'd5) begin
					if (!oui_ok) begin
						add_report(RK_TYPE, TV_UNKNOWN, 6'd0);
						phase = P_SKIP;
					end else begin
						phase = P_VER;
						fbyte = '0;
					end
				end
			end
			P_VER: begin
				if (take_word(b)) begin
					add_report(RK_TYPE, (elem_kind == EK_WPA) ? TV_WPA : TV_RSN, 6'd0);
					add_report(RK_VERSION, word_acc, 6'd0);
					if (elem_len < nxt + 4) begin
						add_report(RK_GROUP, CIPHER_TKIP, 6'd0);
						add_report(RK_PCIPHER, CIPHER_TKIP, 6'd0);
						add_report(RK_PCOUNT, 16'd1, 6'd0);
						phase = P_SKIP;
					end else begin
						phase = P_GROUP;
						open_suite();
					end
				end
			end
			P_GROUP: begin
				if (take_suite(b)) begin
					add_report(RK_GROUP, cipher_of(b), 6'd0);
					if (elem_len < nxt + 2) begin
						add_report(RK_PCIPHER, CIPHER_TKIP, 6'd0);
						add_report(RK_PCOUNT, 16'd1, 6'd0);
						phase = P_SKIP;
					end else begin
						phase = P_PCNT;
						fbyte = '0;
					end
				end
			end
			P_PCNT: begin
				if (take_word(b)) begin
					list_cnt = word_acc;
					list_idx = '0;
					add_report(RK_PCOUNT, list_cnt, 6'd0);
					if (elem_len < nxt + 4 * list_cnt) begin
						phase = P_SKIP;
					end else if (list_cnt != 16'd0) begin
						phase = P_PLIST;
						open_suite();
					end else if (elem_len < nxt + 2) begin
						phase = P_SKIP;
					end else begin
						phase = P_ACNT;
						fbyte = '0;
					end
				end
			end
			P_PLIST: begin
				if (take_suite(b)) begin
					add_report(RK_PCIPHER, cipher_of(b), list_idx);
					list_idx = list_idx + 6'd1;
					open_suite();
					if (list_idx >= list_cnt) begin
						if (elem_len < nxt + 2) begin
							phase = P_SKIP;
						end else begin
							phase = P_ACNT;
							fbyte = '0;
						end
					end
				end
			end
			P_ACNT: begin
				if (take_word(b)) begin
					list_cnt = word_acc;
					list_idx = '0;
					add_report(RK_ACOUNT, list_cnt, 6'd0);
					if (elem_len < nxt + 4 * list_cnt) begin
						phase = P_SKIP;
					end else if (list_cnt != 16'd0) begin
						phase = P_ALIST;
						open_suite();
					end else begin
						phase = (elem_len < nxt + 1) ? P_SKIP : P_CAP;
					end
				end
			end
			P_ALIST: begin
				if (take_suite(b)) begin
					add_report(RK_ASUITE, auth_of(b), list_idx);
					list_idx = list_idx + 6'd1;
					open_suite();
					if (list_idx >= list_cnt)
						phase = (elem_len < nxt + 1) ? P_SKIP : P_CAP;
				end
			end
			P_CAP: begin
				add_report(RK_PREAUTH, {15'd0, b[0]}, 6'd0);
				phase = P_SKIP;
			end
			default: begin
				phase = P_SKIP;
			end
		endcase
		bytes_left = bytes_left - 13'd1;
		if (nxt >= elem_len) begin
			phase = P_HDR;
			elem_pos = '0;
		end else begin
			elem_pos = nxt[8:0];
		end
		if (predicted_reports.size() > n_before)
			predicted_reports[predicted_reports.size() - 1].last_of_run = 1'b1;
	endtask

	function automatic logic [7:0] rnd_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic void push_beat(input logic [7:0] b, input logic st,
			input logic [12:0] blen);
		ie_beat_t t;
		t.b = b;
		t.st = st;
		t.blen = st ? blen : 13'($urandom_range(0, 8191));
		t.gap = src_calm ? 0 : $urandom_range(0, 6);
		ie_stream.push_back(t);
	endfunction

	function automatic void send_buffer(input int len_field);
		int i;
		for (i = 0; i < ie_bytes.size(); i++)
			push_beat(ie_bytes[i], i == 0, 13'(len_field));
		ie_bytes.delete();
	endfunction

	function automatic int pick_count();
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 65535);
			1: return $urandom_range(4, 61);
			default: return $urandom_range(0, 3);
		endcase
	endfunction

	function automatic void add_suite(input logic [31:0] oui);
		int j;
		for (j = 0; j < 3; j++)
			elem_body.push_back(($urandom_range(0, 11) == 0) ? rnd_byte() : oui[8*j +: 8]);
		elem_body.push_back(($urandom_range(0, 3) == 0) ? rnd_byte()
				: 8'($urandom_range(0, 7)));
	endfunction

	function automatic void add_security_ie(input ekind_t k);
		logic [31:0] oui;
		int cnt;
		int cut;
		int i;
		oui = (k == EK_WPA) ? WPA_OUI_WORD : RSN_OUI_WORD;
		elem_body.delete();
		if (k == EK_WPA)
			for (i = 0; i < 4; i++)
				elem_body.push_back(($urandom_range(0, 15) == 0) ? rnd_byte()
						: WPA_OUI_WORD[8*i +: 8]);
		elem_body.push_back(($urandom_range(0, 7) == 0) ? rnd_byte() : 8'h01);
		elem_body.push_back(($urandom_range(0, 7) == 0) ? rnd_byte() : 8'h00);
		add_suite(oui);
		cnt = pick_count();
		elem_body.push_back(cnt[7:0]);
		elem_body.push_back(cnt[15:8]);
		for (i = 0; i < cnt && elem_body.size() < 128; i++)
			add_suite(oui);
		cnt = pick_count();
		elem_body.push_back(cnt[7:0]);
		elem_body.push_back(cnt[15:8]);
		for (i = 0; i < cnt && elem_body.size() < 128; i++)
			add_suite(oui);
		elem_body.push_back(rnd_byte());
		elem_body.push_back(rnd_byte());
		cut = elem_body.size();
		if ($urandom_range(0, 3) == 0)
			cut = $urandom_range(0, cut);
		if (cut > 255)
			cut = 255;
		ie_bytes.push_back((k == EK_WPA) ? IE_VENDOR : IE_RSN);
		ie_bytes.push_back(($urandom_range(0, 9) == 0) ? rnd_byte() : 8'(cut));
		for (i = 0; i < cut; i++)
			ie_bytes.push_back(elem_body[i]);
	endfunction

	function automatic void add_other_ie();
		logic [7:0] t;
		int len;
		int i;
		t = rnd_byte();
		while (t == IE_RSN || t == IE_VENDOR)
			t = rnd_byte();
		len = $urandom_range(0, 12);
		if ($urandom_range(0, 2) != 0) begin
			ie_bytes.push_back(t);
			ie_bytes.push_back(8'(len));
		end
		for (i = 0; i < len; i++)
			ie_bytes.push_back(rnd_byte());
	endfunction

	function automatic void build_directed();
		push_beat(IE_RSN, 1'b1, 13'd0);
		ie_bytes = '{IE_RSN, 8'h14, 8'h01, 8'h00, 8'h00, 8'h0f, 8'hac, 8'h04,
				8'h01, 8'h00, 8'h00, 8'h0f, 8'hac, 8'h04,
				8'h01, 8'h00, 8'h00, 8'h0f, 8'hac, 8'h02, 8'h01, 8'h00};
		send_buffer(22);
		ie_bytes = '{IE_VENDOR, 8'h06, 8'h00, 8'h50, 8'hf2, 8'h01, 8'h01, 8'h00, IE_RSN};
		send_buffer(9);
		push_beat(IE_VENDOR, 1'b0, 13'd0);
		ie_bytes = '{IE_OTHER, 8'h00, IE_VENDOR, 8'h07, 8'h00};
		send_buffer(8191);
		ie_bytes = '{IE_RSN, 8'h06, 8'h01, 8'h00, 8'h00, 8'h0f, 8'hac, 8'h09};
		send_buffer(8);
	endfunction

	function automatic void build_random(input int target);
		int sent;
		int n_el;
		int sz;
		int i;
		int r;
		sent = 0;
		while (sent < target) begin
			src_calm = ($urandom_range(0, 4) == 0);
			n_el = $urandom_range(1, 4);
			for (i = 0; i < n_el; i++) begin
				r = $urandom_range(0, 9);
				if (r < 4)
					add_security_ie(EK_RSN);
				else if (r < 8)
					add_security_ie(EK_WPA);
				else
					add_other_ie();
			end
			sz = ie_bytes.size();
			sent += sz;
			r = $urandom_range(0, 19);
			if (r < 2) begin
				send_buffer($urandom_range(1, sz));
			end else if (r < 4) begin
				send_buffer(sz + $urandom_range(1, 40));
			end else if (r == 4) begin
				send_buffer($urandom_range(MAX_BUFFER_BYTES_DEF + 1, 8191));
			end else begin
				send_buffer(sz);
				if (r == 5)
					for (i = $urandom_range(1, 3); i > 0; i--)
						push_beat(rnd_byte(), 1'b0, 13'd0);
			end
		end
	endfunction

	function automatic void build_tiny_elements();
		int i;
		src_calm = 1'b0;
		for (i = 0; i < 16; i++) begin
			ie_bytes.push_back(IE_RSN);
			ie_bytes.push_back(8'h00);
		end
		send_buffer(ie_bytes.size());
	endfunction

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
			idle_left <= 0;
		end else begin
			if (s_tvalid && s_tready)
				walk_ie_byte(s_tdata[7:0], s_tuser, s_tdata[20:8]);
			if (!s_tvalid || s_tready) begin
				if (idle_left != 0) begin
					s_tvalid <= 1'b0;
					idle_left <= idle_left - 1;
				end else if (ie_stream.size() != 0) begin
					next_beat = ie_stream.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {3'b000, next_beat.blen, next_beat.b};
					s_tuser <= next_beat.st;
					idle_left <= next_beat.gap;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (predicted_reports.size() == 0) begin
					$error("unexpected report: kind %0d value %0d", m_tuser, m_tdata[26:11]);
					err_count++;
				end else begin
					want = predicted_reports.pop_front();
					if (m_tdata[10:0] !== want.element_number) begin
						$error("element_number: expected %0d, actual %0d",
								want.element_number, m_tdata[10:0]);
						err_count++;
					end
					if (m_tuser !== want.report_kind) begin
						$error("report_kind: expected %0d, actual %0d",
								want.report_kind, m_tuser);
						err_count++;
					end
					if (m_tdata[26:11] !== want.report_value) begin
						$error("report_value: expected %0d, actual %0d",
								want.report_value, m_tdata[26:11]);
						err_count++;
					end
					if (m_tdata[32:27] !== want.entry_index) begin
						$error("entry_index: expected %0d, actual %0d",
								want.entry_index, m_tdata[32:27]);
						err_count++;
					end
					if (m_tlast !== want.last_of_run) begin
						$error("last_of_run: expected %0d, actual %0d",
								want.last_of_run, m_tlast);
						err_count++;
					end
				end
				if ($urandom_range(0, 40) == 0)
					sink_calm <= !sink_calm;
				stall_draw = sink_calm ? 0 : $urandom_range(0, 6);
				if (stall_draw == 0) begin
					m_tready <= 1'b1;
				end else begin
					m_tready <= 1'b0;
					stall_left <= stall_draw;
				end
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				m_tready <= (stall_left == 1);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin
		build_directed();
		build_random(70);
		build_tiny_elements();
		build_random(70);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		while (ie_stream.size() != 0 || s_tvalid || predicted_reports.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (err_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/wrp_pkg.sv
rtl/wrp_core.sv
rtl/wrp_fifo.sv
rtl/wpa_rsn_ie_parser.sv
rtl/wrp_checker.sv
tb/tb_top.sv
